@@ design/fmpc_pkg.sv @@
// ----------------------------------------------------------------------------
// fmpc_pkg
// Types and constants for the fleet motion and proximity check unit.
// ----------------------------------------------------------------------------
package fmpc_pkg;

	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_LOAD  = 2'd0;
	localparam func_t FUNC_TICK  = 2'd1;
	localparam func_t FUNC_CLEAR = 2'd2;

	typedef logic cfg_idx_t;
	localparam cfg_idx_t CFG_STEP   = 1'b0;
	localparam cfg_idx_t CFG_MARGIN = 1'b1;

	localparam logic [9:0]  STEP_RESET   = 10'd100;
	localparam logic [15:0] MARGIN_RESET = 16'd512;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [15:0]        speed;
		logic [12:0]        heading;
		logic [15:0]        len;
	} vehicle_t;

	// angle in 1/16 degree
	localparam logic [12:0] ANG_QUARTER = 13'd1440;
	localparam logic [12:0] ANG_HALF    = 13'd2880;
	localparam logic [12:0] ANG_3QUART  = 13'd4320;
	localparam logic [12:0] ANG_FULL    = 13'd5760;

	// (a << 16) / 1440 == ((a << 11) * RECIP_45) >> 28 for a <= 1440
	localparam logic [22:0] RECIP_45   = 23'd5965233;
	// y / 1000 == (y * RECIP_1000) >> 37 for y < 2^27
	localparam logic [27:0] RECIP_1000 = 28'd137438954;
	localparam logic [41:0] HALF_DIV   = 42'd16384000;

	// odd polynomial coefficients, Q30
	localparam logic [31:0] COEF_C9 = 32'd172272;
	localparam logic [31:0] COEF_TAB [4] = '{
		32'd5026995, 32'd85569305, 32'd693598670, 32'd1686629713
	};

	localparam logic [14:0] TRIG_MAX = 15'd32767;

	localparam logic signed [25:0] POS_MAX = 26'sd8388607;
	localparam logic signed [25:0] POS_MIN = -26'sd8388608;

endpackage

@@ design/fleet_motion_proximity_check_unit.sv @@
// ----------------------------------------------------------------------------
// fleet_motion_proximity_check_unit
// Load, clear and tick a table of vehicles; a tick moves every vehicle and
// checks all pairs for proximity, using one shared multiplier throughout.
// A tick with under two vehicles answers in the cycle after it is taken.
// A full tick reads and moves each vehicle, then scans the pairs, and stops
// early when a close pair is found. No new item is taken during a tick.
// Asynchronous active-low reset empties the table and zeroes elapsed time.
// ----------------------------------------------------------------------------
module fleet_motion_proximity_check_unit import fmpc_pkg::*; #(
	parameter int MAX_VEHICLES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [3:0]         slot,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic [15:0]        speed_in,
	input  logic [12:0]        heading,
	input  logic [15:0]        body_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               too_few,
	output logic               collision,
	output logic [4:0]         vehicle_count,
	output logic [31:0]        elapsed_ms,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int IW = $clog2(MAX_VEHICLES);
	localparam int CW = $clog2(MAX_VEHICLES + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_VRD, S_VLAT, S_ANG, S_MT, S_MT2, S_MH0, S_MH, S_MR, S_MS,
		S_MD, S_MU, S_PRI, S_PLI, S_PLJ, S_PDY, S_PM, S_PCMP, S_DONE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [31:0]     time_q;
	logic [9:0]      step_q;
	logic [15:0]     margin_q;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   jdx_q;
	logic [1:0]      k_q;
	logic            axis_q;
	logic            hit_q;
	logic            out_valid_q;
	logic            too_few_q;
	logic            collision_q;
	logic [CW-1:0]   count_q;
	logic [31:0]     elapsed_q;

	// datapath
	vehicle_t        rec_q;
	logic [10:0]     arg_q;
	logic            neg_q;
	logic [16:0]     t_q;
	logic [16:0]     t2_q;
	logic signed [23:0] newx_q;
	logic [24:0]     ady_q;
	logic [16:0]     m_q;
	logic [50:0]     sum_q;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;

	logic              in_acc;
	logic              load_ok;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [IW-1:0]     ram_raddr;
	vehicle_t          ram_wdata;
	vehicle_t          ram_rdata;

	logic [12:0]       h1;
	logic [12:0]       hc;
	logic [12:0]       h2;
	logic [10:0]       arg_d;
	logic              neg_d;
	logic [16:0]       t_d;
	logic [16:0]       t2_d;
	logic [31:0]       p_d;
	logic [48:0]       rnd;
	logic [14:0]       trig_d;
	logic [41:0]       ysum;
	logic [17:0]       d_d;
	logic signed [23:0] pos_sel;
	logic signed [25:0] pos_n;
	logic signed [23:0] pos_d;
	logic signed [24:0] dx;
	logic signed [24:0] dy;
	logic [24:0]       adx;
	logic [24:0]       ady;
	logic [16:0]       m_d;
	logic              close;
	logic [32:0]       time_sum;
	logic [IW-1:0]     jdx_nx;

	assign in_acc  = in_valid & ~in_stall;
	assign load_ok = (32'(slot) < 32'(cnt_q)) ||
	                 ((32'(slot) == 32'(cnt_q)) && (32'(cnt_q) < MAX_VEHICLES));
	assign in_stall  = (state_q != S_IDLE) | (out_valid_q & (func == FUNC_TICK));
	assign cfg_ready = (state_q == S_IDLE);

	assign out_valid     = out_valid_q;
	assign too_few       = too_few_q;
	assign collision     = collision_q;
	assign vehicle_count = 5'(count_q);
	assign elapsed_ms    = elapsed_q;

	assign time_sum = {1'b0, time_q} + 33'(step_q);
	assign jdx_nx   = jdx_q + IW'(1);

	// heading reduction and quadrant fold
	always_comb begin
		h1 = (rec_q.heading >= ANG_FULL) ? rec_q.heading - ANG_FULL : rec_q.heading;
		hc = axis_q ? h1 : h1 + ANG_QUARTER;
		h2 = (hc >= ANG_FULL) ? hc - ANG_FULL : hc;
		if (h2 < ANG_QUARTER) begin
			arg_d = 11'(h2);
			neg_d = 1'b0;
		end else if (h2 < ANG_HALF) begin
			arg_d = 11'(ANG_HALF - h2);
			neg_d = 1'b0;
		end else if (h2 < ANG_3QUART) begin
			arg_d = 11'(h2 - ANG_HALF);
			neg_d = 1'b1;
		end else begin
			arg_d = 11'(ANG_FULL - h2);
			neg_d = 1'b1;
		end
	end

	assign t_d    = prod[44:28];
	assign t2_d   = prod[32:16];
	assign p_d    = COEF_TAB[k_q] - prod[47:16];
	assign rnd    = {1'b0, prod[63:16]} + 49'd16384;
	assign trig_d = (rnd[48:15] > 34'(TRIG_MAX)) ? TRIG_MAX : rnd[29:15];
	assign ysum   = {1'b0, prod[40:0]} + HALF_DIV;
	assign d_d    = prod[54:37];

	// move one axis with saturation
	always_comb begin
		pos_sel = axis_q ? rec_q.y : rec_q.x;
		pos_n   = neg_q ? {{2{pos_sel[23]}}, pos_sel} - $signed({8'd0, d_d})
		                : {{2{pos_sel[23]}}, pos_sel} + $signed({8'd0, d_d});
		if (pos_n > POS_MAX) begin
			pos_d = 24'sh7FFFFF;
		end else if (pos_n < POS_MIN) begin
			pos_d = -24'sh800000;
		end else begin
			pos_d = pos_n[23:0];
		end
	end

	// pair distances
	assign dx    = {rec_q.x[23], rec_q.x} - {ram_rdata.x[23], ram_rdata.x};
	assign dy    = {rec_q.y[23], rec_q.y} - {ram_rdata.y[23], ram_rdata.y};
	assign adx   = dx[24] ? 25'(-dx) : 25'(dx);
	assign ady   = dy[24] ? 25'(-dy) : 25'(dy);
	assign m_d   = ((rec_q.len > ram_rdata.len) ? {1'b0, rec_q.len} : {1'b0, ram_rdata.len})
	               + {1'b0, margin_q};
	assign close = {13'd0, sum_q} <= prod;

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MT: begin
				mul_a = MUL_W'({arg_q, 11'd0});
				mul_b = MUL_W'(RECIP_45);
			end
			S_MT2: begin
				mul_a = MUL_W'(t_d);
				mul_b = MUL_W'(t_d);
			end
			S_MH0: begin
				mul_a = COEF_C9;
				mul_b = MUL_W'(t2_d);
			end
			S_MH: begin
				mul_a = p_d;
				mul_b = (k_q == 2'd3) ? MUL_W'(t_q) : MUL_W'(t2_q);
			end
			S_MR: begin
				mul_a = MUL_W'(trig_d);
				mul_b = MUL_W'(rec_q.speed);
			end
			S_MS: begin
				mul_a = MUL_W'(prod[30:0]);
				mul_b = MUL_W'(step_q);
			end
			S_MD: begin
				mul_a = MUL_W'(ysum[41:15]);
				mul_b = MUL_W'(RECIP_1000);
			end
			S_PLJ: begin
				mul_a = MUL_W'(adx);
				mul_b = MUL_W'(adx);
			end
			S_PDY: begin
				mul_a = MUL_W'(ady_q);
				mul_b = MUL_W'(ady_q);
			end
			S_PM: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(m_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// table port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '{x: newx_q, y: pos_d, speed: rec_q.speed,
		              heading: rec_q.heading, len: rec_q.len};
		ram_raddr = idx_q;
		if (state_q == S_IDLE && in_acc && func == FUNC_LOAD && load_ok) begin
			ram_we    = 1'b1;
			ram_waddr = IW'(slot);
			ram_wdata = '{x: pos_x, y: pos_y, speed: speed_in,
			              heading: heading, len: body_length};
		end else if (state_q == S_MU && axis_q) begin
			ram_we = 1'b1;
		end
		case (state_q)
			S_PLI:  ram_raddr = jdx_q;
			S_PCMP: ram_raddr = jdx_nx;
			default: ram_raddr = idx_q;
		endcase
	end

	fmpc_ram #(
		.WIDTH ($bits(vehicle_t)),
		.DEPTH (MAX_VEHICLES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fmpc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// sequencer and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			time_q      <= '0;
			step_q      <= STEP_RESET;
			margin_q    <= MARGIN_RESET;
			idx_q       <= '0;
			jdx_q       <= '0;
			k_q         <= '0;
			axis_q      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			too_few_q   <= 1'b0;
			collision_q <= 1'b0;
			count_q     <= '0;
			elapsed_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STEP:   step_q   <= cfg_data[9:0];
					CFG_MARGIN: margin_q <= cfg_data;
					default:    step_q   <= step_q;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (func)
							FUNC_LOAD: begin
								if (load_ok && 32'(slot) == 32'(cnt_q)) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							FUNC_CLEAR: begin
								cnt_q  <= '0;
								time_q <= '0;
							end
							FUNC_TICK: begin
								if (32'(cnt_q) < 2) begin
									out_valid_q <= 1'b1;
									too_few_q   <= 1'b1;
									collision_q <= 1'b0;
									count_q     <= cnt_q;
									elapsed_q   <= time_q;
								end else begin
									time_q  <= time_sum[32] ? '1 : time_sum[31:0];
									idx_q   <= '0;
									state_q <= S_VRD;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_VRD:  state_q <= S_VLAT;
				S_VLAT: begin
					axis_q  <= 1'b0;
					state_q <= S_ANG;
				end
				S_ANG:  state_q <= S_MT;
				S_MT:   state_q <= S_MT2;
				S_MT2:  state_q <= S_MH0;
				S_MH0: begin
					k_q     <= '0;
					state_q <= S_MH;
				end
				S_MH: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= S_MR;
					end
				end
				S_MR: state_q <= S_MS;
				S_MS: state_q <= S_MD;
				S_MD: state_q <= S_MU;
				S_MU: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= S_ANG;
					end else if (32'(idx_q) + 1 == 32'(cnt_q)) begin
						idx_q   <= '0;
						jdx_q   <= IW'(1);
						hit_q   <= 1'b0;
						state_q <= S_PRI;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_VRD;
					end
				end
				S_PRI: state_q <= S_PLI;
				S_PLI: state_q <= S_PLJ;
				S_PLJ: state_q <= S_PDY;
				S_PDY: state_q <= S_PM;
				S_PM:  state_q <= S_PCMP;
				S_PCMP: begin
					if (close) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (32'(jdx_q) + 1 < 32'(cnt_q)) begin
						jdx_q   <= jdx_nx;
						state_q <= S_PLJ;
					end else if (32'(idx_q) + 2 < 32'(cnt_q)) begin
						idx_q   <= idx_q + IW'(1);
						jdx_q   <= idx_q + IW'(2);
						state_q <= S_PRI;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					too_few_q   <= 1'b0;
					collision_q <= hit_q;
					count_q     <= cnt_q;
					elapsed_q   <= time_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_VLAT: rec_q <= ram_rdata;
			S_PLI:  rec_q <= ram_rdata;
			S_ANG: begin
				arg_q <= arg_d;
				neg_q <= neg_d;
			end
			S_MT2: t_q  <= t_d;
			S_MH0: t2_q <= t2_d;
			S_MU: begin
				if (!axis_q) begin
					newx_q <= pos_d;
				end
			end
			S_PLJ: begin
				ady_q <= ady;
				m_q   <= m_d;
			end
			S_PDY: sum_q <= 51'(prod[49:0]);
			S_PM:  sum_q <= sum_q + 51'(prod[49:0]);
			default: begin
				t_q <= t_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken during a tick");
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> (out_valid && !too_few))
		else $error("tick result missing");
	a_few_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && too_few) |-> !collision)
		else $error("refused tick reports a collision");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_VEHICLES)
		else $error("vehicle count above table size");
`endif

endmodule

@@ design/fmpc_ram.sv @@
// ----------------------------------------------------------------------------
// fmpc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fmpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/fmpc_mul.sv @@
// ----------------------------------------------------------------------------
// fmpc_mul
// Shared unsigned 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module fmpc_mul import fmpc_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod
);

	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the fleet motion and proximity check unit. Loads, clears and
// ticks are driven with random gaps and output stalls. A fixed-point
// predictor of the fleet table works out each tick word, and every result
// word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import fmpc_pkg::*;

	localparam func_t FUNC_UNUSED = 2'd3;
	localparam int    FLEET_MAX   = 16;

	typedef struct {
		logic        too_few;
		logic        collision;
		logic [4:0]  count;
		logic [31:0] elapsed;
	} tick_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = '0;
	logic [3:0]         slot = '0;
	logic signed [23:0] pos_x = '0;
	logic signed [23:0] pos_y = '0;
	logic [15:0]        speed_in = '0;
	logic [12:0]        heading = '0;
	logic [15:0]        body_length = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               too_few;
	logic               collision;
	logic [4:0]         vehicle_count;
	logic [31:0]        elapsed_ms;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = CFG_STEP;
	logic [15:0]        cfg_data = '0;

	fleet_motion_proximity_check_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the vehicle table
	logic signed [23:0] fx [FLEET_MAX];
	logic signed [23:0] fy [FLEET_MAX];
	logic [15:0]        fspeed [FLEET_MAX];
	logic [12:0]        fhead [FLEET_MAX];
	logic [15:0]        flen [FLEET_MAX];
	int unsigned        fleet = 0;
	logic [31:0]        sim_ms = '0;
	logic [9:0]         step_ms = STEP_RESET;
	logic [15:0]        margin = MARGIN_RESET;

	tick_word_t  tick_words [$];
	int          errors = 0;
	int          items_sent = 0;
	int          ticks_checked = 0;
	int          hits_seen = 0;
	int          refused_seen = 0;
	bit          no_gaps = 1'b0;

	function automatic int quarter_wave(int unsigned a);
		logic [63:0] t, t2, p, r;
		t  = (64'(a) << 16) / 64'd1440;
		t2 = (t * t) >> 16;
		p  = 64'd172272;
		p  = 64'd5026995 - ((p * t2) >> 16);
		p  = 64'd85569305 - ((p * t2) >> 16);
		p  = 64'd693598670 - ((p * t2) >> 16);
		p  = 64'd1686629713 - ((p * t2) >> 16);
		r  = (p * t) >> 16;
		r  = (r + 64'd16384) >> 15;
		if (r > 64'd32767)
			r = 64'd32767;
		return int'(r);
	endfunction

	function automatic int sine_q15(int unsigned h);
		int unsigned q, a;
		h = h % 5760;
		q = h / 1440;
		a = h % 1440;
		case (q)
			0: return quarter_wave(a);
			1: return quarter_wave(1440 - a);
			2: return -quarter_wave(a);
			default: return -quarter_wave(1440 - a);
		endcase
	endfunction

	function automatic logic signed [23:0] advance(logic signed [23:0] p0, int trig,
			logic [15:0] spd);
		longint p, mag, d, n;
		p   = longint'(trig) * longint'(spd) * longint'(step_ms);
		mag = (p < 0) ? -p : p;
		d   = (mag + 64'sd16384000) / 64'sd32768000;
		if (p < 0)
			d = -d;
		n = longint'(p0) + d;
		if (n > 64'sd8388607)
			n = 64'sd8388607;
		if (n < -64'sd8388608)
			n = -64'sd8388608;
		return n[23:0];
	endfunction

	function automatic logic any_pair_close();
		longint dx, dy, m;
		for (int i = 0; i < fleet; i++) begin
			for (int j = i + 1; j < fleet; j++) begin
				dx = longint'(fx[i]) - longint'(fx[j]);
				dy = longint'(fy[i]) - longint'(fy[j]);
				m  = (flen[i] > flen[j]) ? longint'(flen[i]) : longint'(flen[j]);
				m  = m + longint'(margin);
				if (dx * dx + dy * dy <= m * m)
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic update_fleet(func_t f, logic [3:0] s, logic signed [23:0] x,
			logic signed [23:0] y, logic [15:0] spd, logic [12:0] hd, logic [15:0] ln);
		tick_word_t w;
		longint     sum;
		int         sn, cs;
		case (f)
			FUNC_LOAD: begin
				if (s < fleet || (s == fleet && fleet < FLEET_MAX)) begin
					fx[s] = x; fy[s] = y; fspeed[s] = spd; fhead[s] = hd; flen[s] = ln;
					if (s == fleet)
						fleet++;
				end
			end
			FUNC_CLEAR: begin
				fleet  = 0;
				sim_ms = '0;
			end
			FUNC_TICK: begin
				if (fleet < 2) begin
					w = '{1'b1, 1'b0, 5'(fleet), sim_ms};
				end else begin
					sum    = longint'(sim_ms) + longint'(step_ms);
					sim_ms = (sum > 64'sd4294967295) ? 32'hFFFF_FFFF : sum[31:0];
					for (int i = 0; i < fleet; i++) begin
						sn    = sine_q15(fhead[i]);
						cs    = sine_q15(fhead[i] % 5760 + 1440);
						fx[i] = advance(fx[i], cs, fspeed[i]);
						fy[i] = advance(fy[i], sn, fspeed[i]);
					end
					w = '{1'b0, any_pair_close(), 5'(fleet), sim_ms};
				end
				tick_words.insert(tick_words.size(), w);
			end
			default: ;
		endcase
	endtask

	// one word into the block; valid stays high between back-to-back words
	task automatic send_word(func_t f, logic [3:0] s, logic signed [23:0] x,
			logic signed [23:0] y, logic [15:0] spd, logic [12:0] hd, logic [15:0] ln);
		while (!no_gaps && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		slot        <= s;
		pos_x       <= x;
		pos_y       <= y;
		speed_in    <= spd;
		heading     <= hd;
		body_length <= ln;
		do
			@(posedge clk);
		while (in_stall);
		update_fleet(f, s, x, y, spd, hd, ln);
		items_sent++;
	endtask

	task automatic send_load(logic [3:0] s, logic signed [23:0] x, logic signed [23:0] y,
			logic [15:0] spd, logic [12:0] hd, logic [15:0] ln);
		send_word(FUNC_LOAD, s, x, y, spd, hd, ln);
	endtask

	task automatic send_cmd(func_t f);
		send_word(f, 4'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
			13'($urandom), 16'($urandom));
	endtask

	// drop valid and let the last tick and any load or clear behind it finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (tick_words.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_STEP)
			step_ms = data[9:0];
		else
			margin = data;
		@(posedge clk);
	endtask

	task automatic test_small_fleet();
		send_cmd(FUNC_TICK);
		send_load(4'd0, 24'sd1000, -24'sd1000, 16'd256, 13'd0, 16'd256);
		send_cmd(FUNC_TICK);
		send_load(4'd5, '0, '0, '0, '0, '0);   // beyond the end, ignored
		send_cmd(FUNC_UNUSED);
		send_cmd(FUNC_TICK);
		send_cmd(FUNC_CLEAR);
		send_cmd(FUNC_TICK);
	endtask

	task automatic test_extremes();
		send_load(4'd0, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 13'd0, 16'hFFFF);
		send_load(4'd1, 24'sh800000, 24'sh800000, 16'hFFFF, 13'd2880, 16'd0);
		send_cmd(FUNC_TICK);
		send_load(4'd1, 24'sh800000, 24'sh7FFFFF, 16'hFFFF, 13'h1FFF, 16'hFFFF);
		send_load(4'd2, '0, '0, 16'hFFFF, 13'd1440, '0);
		send_load(4'd3, '0, 24'sd100, '0, 13'd4320, '0);   // close to slot 2
		send_cmd(FUNC_TICK);
		send_load(4'd2, 24'sd5000, '0, 16'd1000, 13'd5759, 16'd0);
		send_load(4'd3, 24'sd5000, '0, 16'd1000, 13'd5760, 16'd0);
		send_cmd(FUNC_TICK);
		send_cmd(FUNC_TICK);
		send_cmd(FUNC_CLEAR);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_STEP, 16'hFC00);   // low bits zero: nothing moves
		write_reg(CFG_MARGIN, 16'hFFFF);
		send_load(4'd0, '0, '0, 16'd500, 13'd700, '0);
		send_load(4'd1, 24'sd65535, '0, 16'd500, 13'd700, '0);
		send_cmd(FUNC_TICK);
		drain();
		write_reg(CFG_STEP, 16'h03FF);
		write_reg(CFG_MARGIN, 16'h0000);
		send_cmd(FUNC_TICK);
		drain();
	endtask

	// clear, a fleet in a cluster or scattered, some noise, then a few ticks
	task automatic random_scenario();
		int                 n, spread;
		logic signed [23:0] bx, by;
		send_cmd(FUNC_CLEAR);
		n      = ($urandom_range(9) == 0) ? 16 : $urandom_range(2, 6);
		spread = $urandom_range(1) ? $urandom_range(8, 2000) : 0;
		bx     = 24'($urandom_range(0, 2 ** 23) - 2 ** 22);
		by     = 24'($urandom_range(0, 2 ** 23) - 2 ** 22);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_load(4'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
					13'($urandom), 16'($urandom));
			if (spread != 0)
				send_load(4'(i), bx + 24'($urandom_range(0, 2 * spread) - spread),
					by + 24'($urandom_range(0, 2 * spread) - spread),
					16'($urandom_range(0, 3000)), 13'($urandom_range(0, 8191)),
					16'($urandom_range(0, 600)));
			else
				send_load(4'(i), 24'($urandom), 24'($urandom), 16'($urandom),
					13'($urandom), 16'($urandom));
		end
		if ($urandom_range(7) == 0)
			send_cmd(FUNC_UNUSED);
		repeat ($urandom_range(1, 3)) send_cmd(FUNC_TICK);
	endtask

	task automatic test_random();
		logic [15:0] steps [5]   = '{16'd1, 16'd1000, 16'd37, 16'd100, 16'd1023};
		logic [15:0] margins [5] = '{16'd0, 16'd65535, 16'd300, 16'd512, 16'd2000};
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_reg(CFG_STEP, steps[ph]);
			write_reg(CFG_MARGIN, margins[ph]);
			no_gaps = (ph == 2);
			while (items_sent < 120 * (ph + 1) + 25)
				random_scenario();
		end
		no_gaps = 1'b0;
		drain();
	endtask

	always @(posedge clk)
		out_stall <= !no_gaps && $urandom_range(99) < 16;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (tick_words.size() == 0) begin
				$display("%0t: result word with none expected", $time);
				errors++;
			end else begin
				if (too_few !== tick_words[0].too_few) begin
					$display("%0t: too_few exp %0d got %0d", $time,
						tick_words[0].too_few, too_few);
					errors++;
				end
				if (collision !== tick_words[0].collision) begin
					$display("%0t: collision exp %0d got %0d", $time,
						tick_words[0].collision, collision);
					errors++;
				end
				if (vehicle_count !== tick_words[0].count) begin
					$display("%0t: vehicle_count exp %0d got %0d", $time,
						tick_words[0].count, vehicle_count);
					errors++;
				end
				if (elapsed_ms !== tick_words[0].elapsed) begin
					$display("%0t: elapsed_ms exp %0d got %0d", $time,
						tick_words[0].elapsed, elapsed_ms);
					errors++;
				end
				hits_seen    += tick_words[0].collision;
				refused_seen += tick_words[0].too_few;
				ticks_checked++;
				void'(tick_words.pop_front());
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_fleet();
		test_extremes();
		test_register_extremes();
		test_random();
		repeat (50) @(posedge clk);
		$display("%0d words sent, %0d tick results checked", items_sent, ticks_checked);
		$display("%0d refused ticks, %0d ticks with a close pair", refused_seen, hits_seen);
		if (errors == 0 && tick_words.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
